// ===== hdl/fbrm_pkg.sv =====
`default_nettype none

package fbrm_pkg;

  // Slot numbers travel as three bits on both channels.
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 32;

  typedef enum logic [2:0] {
    OP_BUF_REQ   = 3'd0,
    OP_FRAME_END = 3'd1,
    OP_ACQUIRE   = 3'd2,
    OP_RELEASE   = 3'd3,
    OP_START     = 3'd4,
    OP_STOP      = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STOLE     = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_RECYCLED  = 3'd4,
    ST_LOST      = 3'd5
  } status_t;

  // Commands from the event decoder to one slot FIFO.
  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
    logic              fill;    // load every slot in ascending order
    logic              clear;   // empty the queue
  } fifo_ctl_t;

  // What one slot FIFO shows back to the decoder.
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] head_slot;
  } fifo_sts_t;

endpackage

`default_nettype wire

// ===== hdl/fbrm_slot_fifo.sv =====
`default_nettype none

module fbrm_slot_fifo #(
  parameter int SLOT_COUNT = 3
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire fbrm_pkg::fifo_ctl_t ctl,
  output fbrm_pkg::fifo_sts_t      sts
);

  localparam int HW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int SW = $clog2(2 * SLOT_COUNT);

  logic [fbrm_pkg::SLOT_W-1:0] entry_r [SLOT_COUNT];
  logic [HW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;

  logic          full, empty, do_push, do_pop;
  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail_idx;

  assign full    = (count_r == CW'(SLOT_COUNT));
  assign empty   = (count_r == '0);
  assign do_push = ctl.push && !full;
  assign do_pop  = ctl.pop && !empty;

  // The tail sits count entries past the head, wrapping at the slot count.
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail_idx = (tail_sum >= SW'(SLOT_COUNT)) ? HW'(tail_sum - SW'(SLOT_COUNT))
                                                  : HW'(tail_sum);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.fill) begin
      head_nxt  = '0;
      count_nxt = CW'(SLOT_COUNT);
    end else if (ctl.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (do_pop) begin
        head_nxt = (head_r == HW'(SLOT_COUNT - 1)) ? '0 : head_r + HW'(1);
      end
      count_nxt = count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Slot storage has no reset: the count guards every read.
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        entry_r[i] <= fbrm_pkg::SLOT_W'(i);
      end
    end else if (do_push) begin
      entry_r[tail_idx] <= ctl.push_slot;
    end
  end

  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.head_slot = entry_r[head_r];

endmodule

`default_nettype wire

// ===== hdl/frame_buffer_rotation_manager.sv =====
// A transaction accepted on the input is held in the input register and moves into the
// output stage once that stage is empty or its result is being taken; it is offered from there.
// Throughput: one event per cycle while out_tready is high; each event is decoded in a single
// pass between the input and output registers, with the slot FIFOs and counters updated then.
// Reset (rst_n, synchronous, active low) empties both slot FIFOs, clears all counters,
// leaves the block stopped and drops any transaction in flight.
`default_nettype none

module frame_buffer_rotation_manager #(
  parameter int SLOT_COUNT = 3
) (
  input  wire          clk,
  input  wire          rst_n,
  // Input events.
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,   // [2:0] slot_in, [7:3] zero
  input  wire  [2:0]   in_tuser,   // [2:0] opcode
  // Results, one per event.
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [103:0] out_tdata   // [0] granted, [3:1] slot_out, [6:4] status,
                                   // [38:7] sequence_res, [70:39] frames_done,
                                   // [102:71] drops, [103] zero
);

  localparam int SLOT_W = fbrm_pkg::SLOT_W;
  localparam int CNT_W  = fbrm_pkg::CNT_W;

  // Input register stage.
  logic              s1_valid_r;
  fbrm_pkg::op_t     s1_op_r;
  logic [SLOT_W-1:0] s1_slot_r;

  // Output register stage.
  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [SLOT_W-1:0]    out_slot_r;
  fbrm_pkg::status_t    out_status_r;
  logic [CNT_W-1:0]     out_seq_r;
  logic [CNT_W-1:0]     out_frames_r;
  logic [CNT_W-1:0]     out_drops_r;

  // Persistent block state.
  logic             running_r, running_nxt;
  logic [CNT_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [CNT_W-1:0] drop_cnt_r, drop_cnt_nxt;
  logic [CNT_W-1:0] acq_cnt_r, acq_cnt_nxt;

  fbrm_pkg::fifo_ctl_t free_ctl, ready_ctl;
  fbrm_pkg::fifo_sts_t free_sts, ready_sts;

  logic              in_acc;
  logic              proc;
  logic              slot_ok;
  logic              granted;
  logic [SLOT_W-1:0] slot_out;
  fbrm_pkg::status_t status;
  logic [CNT_W-1:0]  seq;

  // The event held in the input register is processed whenever the output
  // register is empty or its transaction completes in this cycle, so the
  // pipeline keeps moving at one event per cycle under continuous flow.
  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= fbrm_pkg::op_t'(in_tuser);
      s1_slot_r <= in_tdata[SLOT_W-1:0];
    end
  end

  // Slot numbers at or beyond the slot count are ignored by frame end and release.
  assign slot_ok = ({1'b0, s1_slot_r} < (SLOT_W + 1)'(SLOT_COUNT));

  // Event decoder: one pass decides the result and the state update.
  always_comb begin
    granted       = 1'b0;
    slot_out      = '0;
    status        = fbrm_pkg::ST_IGNORED;
    seq           = '0;
    running_nxt   = running_r;
    frame_cnt_nxt = frame_cnt_r;
    drop_cnt_nxt  = drop_cnt_r;
    acq_cnt_nxt   = acq_cnt_r;
    free_ctl      = '0;
    ready_ctl     = '0;
    free_ctl.push_slot  = s1_slot_r;
    ready_ctl.push_slot = s1_slot_r;

    if (proc) begin
      unique case (s1_op_r)
        fbrm_pkg::OP_BUF_REQ: begin
          // Take the oldest free slot; failing that, steal the oldest ready frame.
          if (!free_sts.empty) begin
            free_ctl.pop = 1'b1;
            granted      = 1'b1;
            slot_out     = free_sts.head_slot;
            status       = fbrm_pkg::ST_OK;
          end else if (!ready_sts.empty) begin
            ready_ctl.pop = 1'b1;
            drop_cnt_nxt  = drop_cnt_r + 1'b1;
            granted       = 1'b1;
            slot_out      = ready_sts.head_slot;
            status        = fbrm_pkg::ST_STOLE;
          end else begin
            drop_cnt_nxt = drop_cnt_r + 1'b1;
            status       = fbrm_pkg::ST_REFUSED;
          end
        end
        fbrm_pkg::OP_FRAME_END: begin
          if (slot_ok) begin
            frame_cnt_nxt = frame_cnt_r + 1'b1;
            if (!ready_sts.full) begin
              ready_ctl.push = 1'b1;
              granted        = 1'b1;
              status         = fbrm_pkg::ST_OK;
            end else begin
              // Ready queue full: the frame is dropped and its slot recycled.
              // The FIFO discards the push when the free queue is full too.
              free_ctl.push = 1'b1;
              drop_cnt_nxt  = drop_cnt_r + 1'b1;
              status        = fbrm_pkg::ST_RECYCLED;
            end
          end
        end
        fbrm_pkg::OP_ACQUIRE: begin
          if (running_r) begin
            if (!ready_sts.empty) begin
              ready_ctl.pop = 1'b1;
              acq_cnt_nxt   = acq_cnt_r + 1'b1;
              granted       = 1'b1;
              slot_out      = ready_sts.head_slot;
              status        = fbrm_pkg::ST_OK;
              seq           = acq_cnt_r + 1'b1;
            end else begin
              status = fbrm_pkg::ST_REFUSED;
            end
          end
        end
        fbrm_pkg::OP_RELEASE: begin
          if (slot_ok) begin
            if (!free_sts.full) begin
              free_ctl.push = 1'b1;
              granted       = 1'b1;
              status        = fbrm_pkg::ST_OK;
            end else begin
              status = fbrm_pkg::ST_LOST;
            end
          end
        end
        fbrm_pkg::OP_START: begin
          // A start while already running changes nothing.
          if (!running_r) begin
            free_ctl.fill   = 1'b1;
            ready_ctl.clear = 1'b1;
            running_nxt     = 1'b1;
          end
          granted = 1'b1;
          status  = fbrm_pkg::ST_OK;
        end
        fbrm_pkg::OP_STOP: begin
          running_nxt = 1'b0;
          granted     = 1'b1;
          status      = fbrm_pkg::ST_OK;
        end
        default: begin
          // Unused opcodes are reported as ignored.
          status = fbrm_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      frame_cnt_r <= '0;
      drop_cnt_r  <= '0;
      acq_cnt_r   <= '0;
    end else begin
      running_r   <= running_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      acq_cnt_r   <= acq_cnt_nxt;
    end
  end

  fbrm_slot_fifo #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_free_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (free_ctl),
    .sts  (free_sts)
  );

  fbrm_slot_fifo #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ready_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ready_ctl),
    .sts  (ready_sts)
  );

  // Output register: filled on each processed event, emptied when its
  // transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_granted_r <= granted;
      out_slot_r    <= slot_out;
      out_status_r  <= status;
      out_seq_r     <= seq;
      out_frames_r  <= frame_cnt_nxt;
      out_drops_r   <= drop_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_drops_r, out_frames_r, out_seq_r,
                       out_status_r, out_slot_r, out_granted_r};

endmodule

`default_nettype wire

// ===== hdl/fbrm_checker.sv =====
`default_nettype none

module fbrm_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [103:0] out_tdata
);

  logic       granted;
  logic [2:0] slot_out;
  logic [2:0] status;
  logic       in_acc;

  assign granted  = out_tdata[0];
  assign slot_out = out_tdata[3:1];
  assign status   = out_tdata[6:4];
  assign in_acc   = in_tvalid && in_tready;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A result that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before transfer");

  // Only success and theft of a ready frame come with a grant.
  a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (granted == (status == fbrm_pkg::ST_OK || status == fbrm_pkg::ST_STOLE)))
    else $error("grant flag disagrees with status");

  // An event without a grant hands out no slot and no frame number.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !granted |-> (slot_out == 3'd0) && (out_tdata[38:7] == 32'd0))
    else $error("slot or sequence given without a grant");

  // An event accepted while no result is pending yields a result once it has passed the input and output registers.
  a_event_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_tvalid |-> ##2 out_tvalid)
    else $error("accepted event produced no result");

endmodule

bind frame_buffer_rotation_manager fbrm_checker u_fbrm_checker (.*);

`default_nettype wire
